// ===== hdl/gre_pkg.sv =====
// Shared types and constants of the graph reachability engine.
package gre_pkg;

  // Width of a node number on the item channel.
  localparam int NODE_W    = 6;
  localparam int MAX_NODES = 1 << NODE_W;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_TRAVEL = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_ROW_WR,
    ST_SEED,
    ST_WALK,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic rd_src;
    logic wr_row;
    logic clr_all;
    logic seed;
    logic walk;
    logic load_result;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic ok;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/gre_in_if.sv =====
// Item channel into the engine: command and two node numbers.
interface gre_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic [gre_pkg::NODE_W-1:0] from_node;
  logic [gre_pkg::NODE_W-1:0] to_node;

  modport source (output valid, output command, output from_node, output to_node,
                  input ready);
  modport sink   (input valid, input command, input from_node, input to_node,
                  output ready);
endinterface

// ===== hdl/gre_out_if.sv =====
// Result channel out of the engine.
interface gre_out_if;
  logic valid;
  logic ready;
  logic reachable;

  modport source (output valid, output reachable, input ready);
  modport sink   (input valid, input reachable, output ready);
endinterface

// ===== hdl/graph_reachability_engine.sv =====
// Graph reachability engine: one item at a time, edits and reachability queries on
// an adjacency bit matrix held in a single-port-read memory of one row per node.
// Insert and delete read the source row and write it back with the destination bit
// set or cleared; clear and an item with an out-of-range node go straight to the
// result, and clear empties the graph at once through per-row valid bits. A travel
// query seeds the visited and frontier sets from the source row, then walks until
// the frontier is empty and no row read is pending: the walk reads one matrix row
// per cycle from the memory while the frontier is not empty, overlapping the read
// of the next frontier node with the merge of the previous row. The next item is
// taken once the result is in the output register; that register holds it until
// the result transfer, and work on the following item stalls before its own result
// only if the earlier one is still not taken.
module graph_reachability_engine #(
  parameter int NODES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gre_in_if.sink    in_i,
  gre_out_if.source out_o
);

  gre_pkg::ctl_t ctl;
  gre_pkg::sts_t sts;

  gre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  gre_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .command_i   (in_i.command),
    .from_node_i (in_i.from_node),
    .to_node_i   (in_i.to_node),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .reachable_o (out_o.reachable)
  );

endmodule

// ===== hdl/gre_ctrl.sv =====
// Controller state machine of the graph reachability engine.
module gre_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gre_pkg::sts_t sts_i,
  output gre_pkg::ctl_t ctl_o
);

  gre_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gre_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      gre_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = gre_pkg::ST_ISSUE;
        end
      end
      gre_pkg::ST_ISSUE: begin
        priority if (sts_i.cmd == gre_pkg::CMD_CLEAR) begin
          ctl_o.clr_all = 1'b1;
          state_d       = gre_pkg::ST_FINISH;
        end else if (!sts_i.ok) begin
          state_d = gre_pkg::ST_FINISH;
        end else if (sts_i.cmd == gre_pkg::CMD_TRAVEL) begin
          ctl_o.rd_src = 1'b1;
          state_d      = gre_pkg::ST_SEED;
        end else begin
          ctl_o.rd_src = 1'b1;
          state_d      = gre_pkg::ST_ROW_WR;
        end
      end
      gre_pkg::ST_ROW_WR: begin
        ctl_o.wr_row = 1'b1;
        state_d      = gre_pkg::ST_FINISH;
      end
      gre_pkg::ST_SEED: begin
        ctl_o.seed = 1'b1;
        state_d    = gre_pkg::ST_WALK;
      end
      gre_pkg::ST_WALK: begin
        if (sts_i.walk_done) begin
          state_d = gre_pkg::ST_FINISH;
        end else begin
          ctl_o.walk = 1'b1;
        end
      end
      gre_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          ctl_o.load_result = 1'b1;
          state_d           = gre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gre_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/gre_datapath.sv =====
// Datapath: adjacency memory, visited and frontier sets, result register.
module gre_datapath #(
  parameter int NODES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  command_i,
  input  logic [gre_pkg::NODE_W-1:0]  from_node_i,
  input  logic [gre_pkg::NODE_W-1:0]  to_node_i,
  input  gre_pkg::ctl_t               ctl_i,
  output gre_pkg::sts_t               sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        reachable_o
);

  // Only nodes that a node number can address are stored.
  localparam int ROWS  = (NODES < gre_pkg::MAX_NODES) ? NODES : gre_pkg::MAX_NODES;
  localparam int IDX_W = $clog2(ROWS);
  localparam logic [gre_pkg::NODE_W:0] ROWS_L = (gre_pkg::NODE_W + 1)'(ROWS);

  logic [1:0]                 cmd_q;
  logic [gre_pkg::NODE_W-1:0] src_q, dst_q;
  logic                       ok;
  logic [IDX_W-1:0]           src_idx, dst_idx;

  logic [ROWS-1:0] mem_q [ROWS];
  logic [ROWS-1:0] row_vld_q, row_vld_d;
  logic [ROWS-1:0] rd_row_q;
  logic            rd_vld_q, rd_vld_d;
  logic [ROWS-1:0] rd_eff;
  logic [ROWS-1:0] new_row;

  logic [ROWS-1:0] vis_q, vis_d;
  logic [ROWS-1:0] frn_q, frn_d;
  logic            pend_q, pend_d;
  logic [ROWS-1:0] pick_oh;
  logic [IDX_W-1:0] pick_idx;
  logic [ROWS-1:0] fresh;

  logic            rd_en;
  logic [IDX_W-1:0] rd_addr;

  logic            out_valid_q, out_valid_d;
  logic            reachable_q, reachable_d;

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q <= command_i;
      src_q <= from_node_i;
      dst_q <= to_node_i;
    end
  end

  assign ok      = ({1'b0, src_q} < ROWS_L) && ({1'b0, dst_q} < ROWS_L);
  assign src_idx = src_q[IDX_W-1:0];
  assign dst_idx = dst_q[IDX_W-1:0];

  // A row that was never written since the last clear reads as empty.
  assign rd_eff = rd_vld_q ? rd_row_q : '0;

  always_comb begin
    new_row          = rd_eff;
    new_row[dst_idx] = (cmd_q == gre_pkg::CMD_INSERT);
  end

  // Lowest frontier node, isolated by the two's complement trick.
  assign pick_oh = frn_q & (~frn_q + 1'b1);

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < ROWS; i++) begin
      if (pick_oh[i]) begin
        pick_idx = pick_idx | IDX_W'(i);
      end
    end
  end

  assign rd_en   = ctl_i.rd_src | (ctl_i.walk & (|frn_q));
  assign rd_addr = ctl_i.rd_src ? src_idx : pick_idx;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_row) begin
      mem_q[src_idx] <= new_row;
    end
    if (rd_en) begin
      rd_row_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    row_vld_d = row_vld_q;
    if (ctl_i.clr_all) begin
      row_vld_d = '0;
    end else if (ctl_i.wr_row) begin
      row_vld_d[src_idx] = 1'b1;
    end
    rd_vld_d = rd_en ? row_vld_q[rd_addr] : rd_vld_q;
  end

  // The row read in the previous walk cycle merges while the next node is picked.
  assign fresh = pend_q ? (rd_eff & ~vis_q) : '0;

  always_comb begin
    vis_d  = vis_q;
    frn_d  = frn_q;
    pend_d = pend_q;
    priority if (ctl_i.clr_all) begin
      vis_d  = '0;
      frn_d  = '0;
      pend_d = 1'b0;
    end else if (ctl_i.seed) begin
      vis_d  = rd_eff;
      frn_d  = rd_eff;
      pend_d = 1'b0;
    end else if (ctl_i.walk) begin
      vis_d  = vis_q | fresh;
      frn_d  = (frn_q & ~pick_oh) | fresh;
      pend_d = |frn_q;
    end
  end

  always_comb begin
    reachable_d = reachable_q;
    if (ctl_i.load_result) begin
      reachable_d = (cmd_q == gre_pkg::CMD_TRAVEL) && ok && vis_q[dst_idx];
    end
    out_valid_d = ctl_i.load_result | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      vis_q       <= '0;
      frn_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_vld_q   <= row_vld_d;
      rd_vld_q    <= rd_vld_d;
      vis_q       <= vis_d;
      frn_q       <= frn_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reachable_q <= reachable_d;
  end

  assign sts_o.cmd       = gre_pkg::cmd_e'(cmd_q);
  assign sts_o.ok        = ok;
  assign sts_o.walk_done = ~(|frn_q) & ~pend_q;
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign reachable_o = reachable_q;

endmodule

// ===== hdl/gre_checker.sv =====
// Port-level checks of the graph reachability engine and their binding.
module gre_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic reachable_i
);

  logic       in_xfer, out_xfer;
  logic [1:0] open_q;

  assign in_xfer  = in_valid_i & in_ready_i;
  assign out_xfer = out_valid_i & out_ready_i;

  // Items taken in whose result has not been transferred yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(reachable_i))
    else $error("result dropped or changed while stalled");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("new item taken while the previous one is in work");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> open_q != 2'd0)
    else $error("result without an open item");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q != 2'd3)
    else $error("more than two items open");

endmodule

bind graph_reachability_engine gre_checker u_gre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .reachable_i (out_o.reachable)
);
